// ===== rtl/tse_pkg.sv =====
// Shared types and constants for the task schedule evaluator.
package tse_pkg;

    localparam int TIME_W = 20;
    localparam int SUM_W  = 24;
    localparam int AVG_W  = 28;
    localparam int DIV_W  = SUM_W + 8;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [AVG_W-1:0]  AVG_MAX  = {AVG_W{1'b1}};

    localparam int DEF_MAX_TASKS  = 16;
    localparam int DEF_BURST_BITS = 16;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_SJF  = 2'd2;
    localparam logic [1:0] MODE_PRIO = 2'd3;

    localparam logic       CFG_MODE    = 1'b0;
    localparam logic       CFG_QUANTUM = 1'b1;
    localparam logic [7:0] QUANTUM_RESET = 8'd2;

    typedef struct packed {
        logic [15:0] burst;
        logic [4:0]  prio;
        logic        last;
    } t_task_in;

    typedef struct packed {
        logic [3:0]        task_index;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [AVG_W-1:0]  avg_turnaround;
        logic [AVG_W-1:0]  avg_waiting;
        logic              end_of_set;
    } t_result;

endpackage

// ===== rtl/task_schedule_evaluator.sv =====
// Top level of the task schedule evaluator: loader, scheduler sequencer and result divider.
//
// Usage: tasks are loaded one per transfer on i_task while start is high and busy is low.
// A transfer with last set closes the set; busy then rises and the block computes the
// schedule chosen by the mode register (write index 0) with the round robin slice taken
// from the quantum register (write index 1). Registers are to be written on i_cfg_we
// only while idle; the block does not enforce this. Loading transfers give no result.
// After the closing transfer the sequencer walks the task table: stable insertion sort
// for shortest job and priority modes ahead of the sequential run, which first come
// first served runs alone; round robin visits every task turn, done tasks included.
// Results are then put out in load order, one per cycle on o_valid, followed by two
// restoring divisions for the averages, after which the final result carries end_of_set.
// The receiver cannot stall: each result is valid for exactly one cycle. Reset clears
// the task count, the registers and the sequencer; the table contents are left as they
// are and are always written before they are read.
module task_schedule_evaluator #(
    parameter int MAX_TASKS  = tse_pkg::DEF_MAX_TASKS,
    parameter int BURST_BITS = tse_pkg::DEF_BURST_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tse_pkg::t_task_in i_task,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    output logic              o_valid,
    output tse_pkg::t_result  o_result
);
    import tse_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int KW = (BURST_BITS > 5) ? BURST_BITS : 5;
    localparam int AW = ((BURST_BITS > TIME_W) ? BURST_BITS : TIME_W) + 1;
    localparam int DCW = $clog2(DIV_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPICK = 3'd1;
    localparam logic [2:0] ST_SCMP  = 3'd2;
    localparam logic [2:0] ST_SEQ   = 3'd3;
    localparam logic [2:0] ST_RR    = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_LAST  = 3'd7;

    // Task table.
    logic [BURST_BITS-1:0] r_burst [MAX_TASKS];
    logic [4:0]            r_prio  [MAX_TASKS];
    logic [BURST_BITS-1:0] r_rem   [MAX_TASKS];
    logic [TIME_W-1:0]     r_fin   [MAX_TASKS];
    logic [IW-1:0]         r_ord   [MAX_TASKS];
    logic [MAX_TASKS-1:0]  r_done;

    logic [2:0]        r_state;
    logic [1:0]        r_mode;
    logic [7:0]        r_quantum;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_j;
    logic [CW-1:0]     r_left;
    logic [IW-1:0]     r_v;
    logic [KW-1:0]     r_vkey;
    logic [TIME_W-1:0] r_clk;
    logic [SUM_W-1:0]  r_sum_t;
    logic [SUM_W-1:0]  r_sum_w;
    logic [TIME_W-1:0] r_lfin;
    logic [TIME_W-1:0] r_lwt;
    logic [AVG_W-1:0]  r_avg_t;
    logic [DIV_W-1:0]  r_dq;
    logic [CW:0]       r_drem;
    logic [DCW-1:0]    r_dstep;
    logic              r_dphase;
    logic              r_valid;
    t_result           r_res;

    logic              w_accept;
    logic [BURST_BITS-1:0] w_bin;
    logic [CW-1:0]     w_last_i;
    logic [CW-1:0]     w_oaddr;
    logic [IW-1:0]     w_odata;
    logic [IW-1:0]     w_baddr;
    logic [BURST_BITS-1:0] w_bdata;
    logic [KW-1:0]     w_key;
    logic [IW-1:0]     w_ii;
    logic [BURST_BITS-1:0] w_rem;
    logic [7:0]        w_q;
    logic              w_rem_gt_q;
    logic [AW-1:0]     w_add;
    logic [AW-1:0]     w_sum;
    logic [TIME_W-1:0] w_clk_n;
    logic [TIME_W-1:0] w_fin;
    logic [TIME_W-1:0] w_wt;
    logic [SUM_W:0]    w_st;
    logic [SUM_W:0]    w_sw;
    logic [SUM_W-1:0]  w_st_n;
    logic [SUM_W-1:0]  w_sw_n;
    logic [CW:0]       w_rs;
    logic              w_ge;
    logic [DIV_W-1:0]  w_dq_n;
    logic [AVG_W-1:0]  w_avg;
    logic [7:0]        w_idx8;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_bin    = BURST_BITS'(i_task.burst);
    assign w_last_i = r_cnt - CW'(1);
    assign w_ii     = r_i[IW-1:0];

    // The order table has one read address; its data selects the priority entry and, outside output, the burst entry.
    always_comb begin
        case (r_state)
            ST_SCMP: w_oaddr = r_j - CW'(1);
            default: w_oaddr = r_i;
        endcase
    end
    assign w_odata = r_ord[w_oaddr[IW-1:0]];
    assign w_baddr = (r_state == ST_OUT) ? w_ii : w_odata;
    assign w_bdata = r_burst[w_baddr];
    assign w_key   = (r_mode == MODE_SJF) ? KW'(w_bdata) : KW'(r_prio[w_odata]);

    // One saturating time adder shared by the sequential and round robin runs.
    assign w_rem      = r_rem[w_ii];
    assign w_q        = (r_quantum == 8'd0) ? 8'd1 : r_quantum;
    assign w_rem_gt_q = AW'(w_rem) > AW'(w_q);
    always_comb begin
        case (r_state)
            ST_RR:   w_add = w_rem_gt_q ? AW'(w_q) : AW'(w_rem);
            default: w_add = AW'(w_bdata);
        endcase
    end
    assign w_sum   = AW'(r_clk) + w_add;
    assign w_clk_n = (w_sum > AW'(TIME_MAX)) ? TIME_MAX : w_sum[TIME_W-1:0];

    // Result fields and saturating sums.
    assign w_fin  = r_fin[w_ii];
    assign w_wt   = (AW'(w_fin) >= AW'(w_bdata)) ? TIME_W'(AW'(w_fin) - AW'(w_bdata))
                                                 : '0;
    assign w_st   = (SUM_W+1)'(r_sum_t) + (SUM_W+1)'(w_fin);
    assign w_sw   = (SUM_W+1)'(r_sum_w) + (SUM_W+1)'(w_wt);
    assign w_st_n = w_st[SUM_W] ? SUM_MAX : w_st[SUM_W-1:0];
    assign w_sw_n = w_sw[SUM_W] ? SUM_MAX : w_sw[SUM_W-1:0];
    assign w_idx8 = 8'(r_i);

    // Restoring divider step, one quotient bit a cycle.
    assign w_rs   = {r_drem[CW-1:0], r_dq[DIV_W-1]};
    assign w_ge   = w_rs >= {1'b0, r_cnt};
    assign w_dq_n = {r_dq[DIV_W-2:0], w_ge};
    assign w_avg  = (|w_dq_n[DIV_W-1:AVG_W]) ? AVG_MAX : w_dq_n[AVG_W-1:0];

    // Table writes.
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_cnt < CW'(MAX_TASKS))) begin
            r_burst[r_cnt[IW-1:0]] <= w_bin;
            r_prio[r_cnt[IW-1:0]]  <= i_task.prio;
            r_rem[r_cnt[IW-1:0]]   <= w_bin;
            r_ord[r_cnt[IW-1:0]]   <= r_cnt[IW-1:0];
        end
        if (r_state == ST_SCMP) begin
            if ((r_j != '0) && (w_key > r_vkey)) begin
                r_ord[r_j[IW-1:0]] <= w_odata;
            end else begin
                r_ord[r_j[IW-1:0]] <= r_v;
            end
        end
        if (r_state == ST_SEQ) begin
            r_fin[w_odata] <= w_clk_n;
        end
        if ((r_state == ST_RR) && !r_done[w_ii]) begin
            if (r_clk == TIME_MAX) begin
                r_fin[w_ii] <= TIME_MAX;
            end else if (w_rem_gt_q) begin
                r_rem[w_ii] <= w_rem - BURST_BITS'(w_q);
            end else begin
                r_rem[w_ii] <= '0;
                r_fin[w_ii] <= w_clk_n;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SPICK) begin
            r_v    <= w_odata;
            r_vkey <= w_key;
        end
        if (r_state == ST_OUT) begin
            r_res.task_index     <= w_idx8[3:0];
            r_res.completion     <= w_fin;
            r_res.turnaround     <= w_fin;
            r_res.waiting        <= w_wt;
            r_res.avg_turnaround <= '0;
            r_res.avg_waiting    <= '0;
            r_res.end_of_set     <= 1'b0;
            if (r_i == w_last_i) begin
                r_lfin <= w_fin;
                r_lwt  <= w_wt;
            end
        end
        if (r_state == ST_DIV) begin
            if (r_dstep == DCW'(DIV_W - 1)) begin
                if (!r_dphase) begin
                    r_avg_t <= w_avg;
                end else begin
                    r_res.task_index     <= w_idx8[3:0];
                    r_res.completion     <= r_lfin;
                    r_res.turnaround     <= r_lfin;
                    r_res.waiting        <= r_lwt;
                    r_res.avg_turnaround <= r_avg_t;
                    r_res.avg_waiting    <= w_avg;
                    r_res.end_of_set     <= 1'b1;
                end
            end
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= MODE_FCFS;
            r_quantum <= QUANTUM_RESET;
            r_cnt     <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_left    <= '0;
            r_clk     <= '0;
            r_sum_t   <= '0;
            r_sum_w   <= '0;
            r_done    <= '0;
            r_dq      <= '0;
            r_drem    <= '0;
            r_dstep   <= '0;
            r_dphase  <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:    r_mode    <= i_cfg_data[1:0];
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    default:     ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (r_cnt < CW'(MAX_TASKS)) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (i_task.last) begin
                            r_clk  <= '0;
                            r_done <= '0;
                            r_left <= (r_cnt < CW'(MAX_TASKS)) ? r_cnt + CW'(1) : r_cnt;
                            case (r_mode)
                                MODE_RR: begin
                                    r_i     <= '0;
                                    r_state <= ST_RR;
                                end
                                MODE_SJF, MODE_PRIO: begin
                                    r_i     <= CW'(1);
                                    r_state <= ST_SPICK;
                                end
                                default: begin
                                    r_i     <= '0;
                                    r_state <= ST_SEQ;
                                end
                            endcase
                        end
                    end
                end
                ST_SPICK: begin
                    if (r_i == r_cnt) begin
                        r_i     <= '0;
                        r_state <= ST_SEQ;
                    end else begin
                        r_j     <= r_i;
                        r_state <= ST_SCMP;
                    end
                end
                ST_SCMP: begin
                    if ((r_j != '0) && (w_key > r_vkey)) begin
                        r_j <= r_j - CW'(1);
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= ST_SPICK;
                    end
                end
                ST_SEQ: begin
                    r_clk <= w_clk_n;
                    if (r_i == w_last_i) begin
                        r_i     <= '0;
                        r_sum_t <= '0;
                        r_sum_w <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                ST_RR: begin
                    if (!r_done[w_ii]) begin
                        if ((r_clk == TIME_MAX) || !w_rem_gt_q) begin
                            r_done[w_ii] <= 1'b1;
                            r_left       <= r_left - CW'(1);
                        end
                        if (r_clk != TIME_MAX) begin
                            r_clk <= w_clk_n;
                        end
                    end
                    if (!r_done[w_ii] && ((r_clk == TIME_MAX) || !w_rem_gt_q)
                        && (r_left == CW'(1))) begin
                        r_i     <= '0;
                        r_sum_t <= '0;
                        r_sum_w <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_i <= (r_i == w_last_i) ? '0 : r_i + CW'(1);
                    end
                end
                ST_OUT: begin
                    r_sum_t <= w_st_n;
                    r_sum_w <= w_sw_n;
                    if (r_i == w_last_i) begin
                        r_dq     <= {w_st_n, 8'd0};
                        r_drem   <= '0;
                        r_dstep  <= '0;
                        r_dphase <= 1'b0;
                        r_state  <= ST_DIV;
                    end else begin
                        r_valid <= 1'b1;
                        r_i     <= r_i + CW'(1);
                    end
                end
                ST_DIV: begin
                    r_dq    <= w_dq_n;
                    r_drem  <= w_ge ? w_rs - {1'b0, r_cnt} : w_rs;
                    r_dstep <= r_dstep + DCW'(1);
                    if (r_dstep == DCW'(DIV_W - 1)) begin
                        if (!r_dphase) begin
                            r_dq     <= {r_sum_w, 8'd0};
                            r_drem   <= '0;
                            r_dstep  <= '0;
                            r_dphase <= 1'b1;
                        end else begin
                            r_valid <= 1'b1;
                            r_state <= ST_LAST;
                        end
                    end
                end
                ST_LAST: begin
                    r_cnt   <= '0;
                    r_clk   <= '0;
                    r_sum_t <= '0;
                    r_sum_w <= '0;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    // A final result leaves the block idle with an empty table.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.end_of_set) |=> (r_state == ST_IDLE) && (r_cnt == '0))
        else $error("set not closed after final result");

    // The insertion pointer never runs ahead of the element being placed.
    a_sort_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCMP) |-> (r_j <= r_i) && (r_i < r_cnt))
        else $error("sort pointers out of order");

    // Round robin never counts more open tasks than the set holds.
    a_rr_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RR) |-> (r_left != '0) && (r_left <= r_cnt))
        else $error("round robin open count wrong");

    // Work is only ever done on a non-empty set.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt != '0))
        else $error("busy with an empty set");

endmodule

// ===== bench/task_schedule_evaluator_tb.sv =====
// Self-checking testbench for the task schedule evaluator: directed and random task sets.
`timescale 1ns / 1ps

module task_schedule_evaluator_tb;
    import tse_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_task_in    i_task = '0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_MODE;
    logic [7:0]  i_cfg_data = '0;
    logic        o_valid;
    t_result     o_result;

    task_schedule_evaluator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_task     (i_task),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Tasks waiting to be driven, and schedule results still to come out of the block.
    t_task_in   task_queue[$];
    t_result    result_queue[$];

    // Our own copy of the block's registers and task table.
    logic [1:0]  cur_mode = MODE_FCFS;
    logic [7:0]  cur_quantum = QUANTUM_RESET;
    logic [15:0] held_burst[16];
    logic [4:0]  held_prio[16];
    int          held_count = 0;

    int error_count = 0;
    int task_total = 0;
    int set_total = 0;
    int result_total = 0;
    int overflow_sets = 0;
    int mode_sets[4] = '{0, 0, 0, 0};

    function automatic logic [TIME_W-1:0] time_add(logic [TIME_W-1:0] a, longint d);
        longint s;
        s = longint'(a) + d;
        return (s > longint'(TIME_MAX)) ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(logic [SUM_W-1:0] a, longint d);
        longint s;
        s = longint'(a) + d;
        return (s > longint'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // Applies one accepted task to the table. When the task closes the set, the chosen
    // schedule is worked out and the results are queued in load order.
    task automatic schedule_task(input t_task_in t);
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] finish[16];
        logic [15:0]       remaining[16];
        logic              done[16];
        logic [SUM_W-1:0]  sum_tat;
        logic [SUM_W-1:0]  sum_wait;
        logic [TIME_W-1:0] wt;
        longint            avg;
        int                order[16];
        int                n, i, j, v, left, q, key_a, key_b;
        t_result           r;
        if (held_count < 16) begin
            held_burst[held_count] = t.burst;
            held_prio[held_count] = t.prio;
            held_count++;
        end else if (t.last) begin
            overflow_sets++;
        end
        if (!t.last) return;

        n = held_count;
        now = '0;
        set_total++;
        mode_sets[cur_mode]++;
        if (cur_mode == MODE_RR) begin
            // Each task in load order gets at most one slice per pass; a task whose
            // remaining time fits the slice, a zero burst included, finishes on that turn.
            q = (cur_quantum == 0) ? 1 : int'(cur_quantum);
            for (i = 0; i < n; i++) begin
                remaining[i] = held_burst[i];
                done[i] = 1'b0;
            end
            left = n;
            while (left > 0) begin
                for (i = 0; i < n; i++) begin
                    if (!done[i]) begin
                        if (now >= TIME_MAX) begin
                            finish[i] = TIME_MAX;
                            done[i] = 1'b1;
                            left--;
                        end else if (int'(remaining[i]) > q) begin
                            now = time_add(now, q);
                            remaining[i] = remaining[i] - q[15:0];
                        end else begin
                            now = time_add(now, remaining[i]);
                            remaining[i] = '0;
                            finish[i] = now;
                            done[i] = 1'b1;
                            left--;
                        end
                    end
                end
            end
        end else begin
            for (i = 0; i < n; i++) order[i] = i;
            if (cur_mode == MODE_SJF || cur_mode == MODE_PRIO) begin
                // Stable insertion sort: only a strictly larger key moves back.
                for (i = 1; i < n; i++) begin
                    v = order[i];
                    j = i;
                    while (j > 0) begin
                        key_a = (cur_mode == MODE_SJF) ? held_burst[order[j-1]]
                                                       : held_prio[order[j-1]];
                        key_b = (cur_mode == MODE_SJF) ? held_burst[v] : held_prio[v];
                        if (key_a <= key_b) break;
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = v;
                end
            end
            for (i = 0; i < n; i++) begin
                now = time_add(now, held_burst[order[i]]);
                finish[order[i]] = now;
            end
        end

        sum_tat = '0;
        sum_wait = '0;
        for (i = 0; i < n; i++) begin
            wt = (finish[i] >= held_burst[i]) ? finish[i] - held_burst[i] : '0;
            sum_tat = sum_add(sum_tat, finish[i]);
            sum_wait = sum_add(sum_wait, wt);
            r = '0;
            r.task_index = i[3:0];
            r.completion = finish[i];
            r.turnaround = finish[i];
            r.waiting = wt;
            if (i == n - 1) begin
                avg = (longint'(sum_tat) << 8) / n;
                r.avg_turnaround = (avg > longint'(AVG_MAX)) ? AVG_MAX : avg[AVG_W-1:0];
                avg = (longint'(sum_wait) << 8) / n;
                r.avg_waiting = (avg > longint'(AVG_MAX)) ? AVG_MAX : avg[AVG_W-1:0];
                r.end_of_set = 1'b1;
            end
            result_queue.push_back(r);
        end
        held_count = 0;
    endtask

    // Driver: the sender works in bursts of transfers separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                schedule_task(i_task);
                task_total++;
            end
            if (start && busy) begin
                // The offered task has not been taken yet; hold it.
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (task_queue.size() > 0) begin
                i_task <= task_queue.pop_front();
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Monitor: every strobed result is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid) begin
            result_total++;
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result, task_index %0d", $time,
                         o_result.task_index);
                error_count++;
            end else begin
                exp_r = result_queue.pop_front();
                report_field("task_index", exp_r.task_index, o_result.task_index);
                report_field("completion", exp_r.completion, o_result.completion);
                report_field("turnaround", exp_r.turnaround, o_result.turnaround);
                report_field("waiting", exp_r.waiting, o_result.waiting);
                report_field("avg_turnaround", exp_r.avg_turnaround,
                             o_result.avg_turnaround);
                report_field("avg_waiting", exp_r.avg_waiting, o_result.avg_waiting);
                report_field("end_of_set", exp_r.end_of_set, o_result.end_of_set);
            end
        end
    end

    // Register writes happen only while the block is idle, so the local copy is
    // updated at once.
    task automatic write_reg(input logic idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MODE) cur_mode = data[1:0];
        else cur_quantum = data;
    endtask

    task automatic add_task(input logic [15:0] b, input logic [4:0] p, input logic l);
        t_task_in t;
        t.burst = b;
        t.prio = p;
        t.last = l;
        task_queue.push_back(t);
    endtask

    // Waits until every queued task is taken, every result is back and the block is idle,
    // then lets the clock run on before a register may change.
    task automatic settle();
        do @(posedge i_clk);
        while (task_queue.size() > 0 || start || result_queue.size() > 0 || busy);
        repeat (100) @(posedge i_clk);
    endtask

    // Round robin takes a turn per slice, so bursts are kept to at most forty slices there.
    function automatic logic [15:0] pick_burst();
        int lim;
        lim = 65535;
        if (cur_mode == MODE_RR)
            lim = ((cur_quantum == 0) ? 1 : int'(cur_quantum)) * 40;
        if (lim > 65535) lim = 65535;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return lim[15:0];
            2, 3: return 16'($urandom_range(0, lim));
            default: return 16'($urandom_range(0, (lim < 40) ? lim : 40));
        endcase
    endfunction

    task automatic random_set();
        int n, i;
        // Mostly modest sets; now and then a full table or one that overflows it.
        case ($urandom_range(0, 9))
            0: n = $urandom_range(16, 19);
            1: n = 1;
            default: n = $urandom_range(2, 10);
        endcase
        for (i = 0; i < n; i++)
            add_task(pick_burst(), 5'($urandom_range(0, 31)), i == n - 1);
    endtask

    initial begin
        int k, s;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, first come first served: extreme bursts and priorities.
        add_task(16'hFFFF, 5'd31, 1'b0);
        add_task(16'h0000, 5'd0, 1'b0);
        add_task(16'd3, 5'd20, 1'b0);
        add_task(16'hFFFF, 5'd1, 1'b1);
        // A single task set.
        add_task(16'd7, 5'd5, 1'b1);
        settle();

        // Round robin with a slice of one, zero bursts finishing on their first turn.
        write_reg(CFG_MODE, {6'd0, MODE_RR});
        write_reg(CFG_QUANTUM, 8'd1);
        add_task(16'd0, 5'd3, 1'b0);
        add_task(16'd4, 5'd3, 1'b0);
        add_task(16'd0, 5'd3, 1'b0);
        add_task(16'd2, 5'd3, 1'b1);
        settle();
        // The widest slice with the longest burst, and a zero slice acting as one.
        write_reg(CFG_QUANTUM, 8'd255);
        add_task(16'hFFFF, 5'd2, 1'b0);
        add_task(16'd300, 5'd2, 1'b1);
        settle();
        write_reg(CFG_QUANTUM, 8'd0);
        add_task(16'd3, 5'd2, 1'b0);
        add_task(16'd1, 5'd2, 1'b1);
        settle();

        // Shortest job with equal bursts to show the sort keeps load order.
        write_reg(CFG_MODE, {6'd0, MODE_SJF});
        add_task(16'd9, 5'd1, 1'b0);
        add_task(16'd2, 5'd1, 1'b0);
        add_task(16'd9, 5'd1, 1'b0);
        add_task(16'd2, 5'd1, 1'b1);
        settle();
        // Priority with ties and the extremes of the field.
        write_reg(CFG_MODE, {6'd0, MODE_PRIO});
        add_task(16'd5, 5'd31, 1'b0);
        add_task(16'd6, 5'd0, 1'b0);
        add_task(16'd7, 5'd31, 1'b0);
        add_task(16'hFFFF, 5'd0, 1'b1);
        settle();

        // Random phases: a fresh mode and slice, then several sets under them.
        while (task_total < 370) begin
            write_reg(CFG_MODE, {6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))});
            case ($urandom_range(0, 3))
                0: k = 1;
                1: k = 255;
                default: k = $urandom_range(0, 255);
            endcase
            write_reg(CFG_QUANTUM, k[7:0]);
            for (s = 0; s < $urandom_range(2, 6); s++) random_set();
            settle();
        end

        $display("Ran %0d tasks in %0d sets (%0d overflowing the table), %0d results.",
                 task_total, set_total, overflow_sets, result_total);
        $display("Sets per mode: fcfs %0d, round robin %0d, shortest job %0d, priority %0d.",
                 mode_sets[0], mode_sets[1], mode_sets[2], mode_sets[3]);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog in case the block stops answering.
    initial begin
        #6000000;
        $display("Timeout waiting for results.");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
